FILE: rtl/rff_pkg.sv
`default_nettype none

package rff_pkg;

	localparam logic [7:0] HEAD_BYTE = 8'hEF;
	localparam logic [7:0] RANGE_MSG = 8'h51;
	localparam logic [7:0] RANGE_LEN = 8'd20;

	// Payload byte offsets of the fields that are kept.
	localparam logic [7:0] OFF_DIST_B0  = 8'd4;
	localparam logic [7:0] OFF_DIST_B1  = 8'd5;
	localparam logic [7:0] OFF_DIST_B2  = 8'd6;
	localparam logic [7:0] OFF_DIST_B3  = 8'd7;
	localparam logic [7:0] OFF_STRENGTH = 8'd8;
	localparam logic [7:0] OFF_VX_LO    = 8'd12;
	localparam logic [7:0] OFF_VX_HI    = 8'd13;
	localparam logic [7:0] OFF_VY_LO    = 8'd14;
	localparam logic [7:0] OFF_VY_HI    = 8'd15;
	localparam logic [7:0] OFF_QUALITY  = 8'd16;

	// Flow scaling: a product magnitude at or above these limits saturates.
	localparam int unsigned FLOW_DIV     = 1000;
	localparam logic [47:0] SAT_POS_MAG  = 48'(32768 * FLOW_DIV);
	localparam logic [47:0] SAT_NEG_MAG  = 48'(32769 * FLOW_DIV);
	// Below the limits m / 1000 = (m / 8) / 125, and (m / 8) < 2**22, so
	// x / 125 = (x * ceil(2**29 / 125)) >> 29 is exact over that range.
	localparam int          RECIP_SHIFT  = 29;
	localparam logic [22:0] RECIP_125    = 23'd4294968;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DEV,
		PH_SYS,
		PH_MSG,
		PH_SEQ,
		PH_LEN,
		PH_PAY,
		PH_SUM
	} phase_t;

	typedef struct packed {
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [31:0] distance;
		logic [7:0]  strength;
		logic [7:0]  quality;
	} frame_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

FILE: rtl/rff_if.sv
`default_nettype none

interface rff_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rff_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] flow_x;
	logic signed [15:0] flow_y;
	logic        [7:0]  optic_quality;
	logic        [31:0] range_dist;
	logic        [7:0]  signal_strength;

	modport source (output valid, output flow_x, output flow_y, output optic_quality,
		output range_dist, output signal_strength, input ready);
	modport sink   (input valid, input flow_x, input flow_y, input optic_quality,
		input range_dist, input signal_strength, output ready);
endinterface

`default_nettype wire

FILE: rtl/range_flow_frame_parser.sv
`default_nettype none

// Channel  Dir  Payload                                                    Request
// rx       in   rx_byte                                                    one received byte
// result   out  flow_x, flow_y, optic_quality, range_dist, signal_strength  one good frame
//
// One byte is taken every cycle while rx.ready is high; a frame with a good checksum,
// message type 0x51 and a 20-byte payload gives a result once its checksum byte is taken.
// The result passes the frame register, the flow multiplier and the divide-by-1000
// reciprocal multiplier with saturation, which also drives the result register.
// Reset returns the parser to the head-byte hunt and empties every stage.
// A stage refills whenever the stage after it moves, so a waiting result stalls input
// only when all three stages are full.

module range_flow_frame_parser #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rff_byte_if.sink     rx,
	rff_result_if.source result
);

	rff_pkg::stage_en_t en;
	rff_pkg::frame_t    frame_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               take;

	logic [31:0] distance_s2;
	logic [7:0]  strength_s2;
	logic [7:0]  quality_s2;
	logic [31:0] distance_s3;
	logic [7:0]  strength_s3;
	logic [7:0]  quality_s3;
	logic signed [15:0] flow_x_s3;
	logic signed [15:0] flow_y_s3;

	assign en.s3 = !valid_s3 || result.ready;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign rx.ready = en.s1;
	assign take     = rx.valid && en.s1;

	rff_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx.rx_byte),
		.en       (en),
		.valid_s1 (valid_s1),
		.frame_s1 (frame_s1)
	);

	rff_flow_scale u_scale_x (
		.clk      (clk),
		.en       (en),
		.vel      (frame_s1.vel_x),
		.distance (frame_s1.distance),
		.flow_s3  (flow_x_s3)
	);

	rff_flow_scale u_scale_y (
		.clk      (clk),
		.en       (en),
		.vel      (frame_s1.vel_y),
		.distance (frame_s1.distance),
		.flow_s3  (flow_y_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			distance_s2 <= frame_s1.distance;
			strength_s2 <= frame_s1.strength;
			quality_s2  <= frame_s1.quality;
		end
		if (en.s3) begin
			distance_s3 <= distance_s2;
			strength_s3 <= strength_s2;
			quality_s3  <= quality_s2;
		end
	end

	assign result.valid           = valid_s3;
	assign result.flow_x          = flow_x_s3;
	assign result.flow_y          = flow_y_s3;
	assign result.optic_quality   = quality_s3;
	assign result.range_dist      = distance_s3;
	assign result.signal_strength = strength_s3;

endmodule

`default_nettype wire

FILE: rtl/rff_parser.sv
`default_nettype none

module rff_parser #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         rx_byte,
	input  wire rff_pkg::stage_en_t en,
	output logic                    valid_s1,
	output rff_pkg::frame_t         frame_s1
);

	localparam int         CntW   = $clog2(MAX_PAYLOAD + 1);
	localparam logic [7:0] LenMax = 8'(MAX_PAYLOAD);

	rff_pkg::phase_t phase_q, phase_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      len_q, len_d;
	logic [7:0]      msg_q, msg_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [CntW-1:0] cnt_inc;
	logic            hit;

	logic [31:0] dist_q;
	logic [7:0]  strength_q;
	logic [15:0] vel_x_q;
	logic [15:0] vel_y_q;
	logic [7:0]  quality_q;

	assign cnt_inc = cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rff_pkg::PH_HUNT;
			sum_q   <= '0;
			len_q   <= '0;
			msg_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			msg_q   <= msg_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		msg_d   = msg_q;
		cnt_d   = cnt_q;
		hit     = 1'b0;
		if (take) begin
			case (phase_q)
				rff_pkg::PH_HUNT: begin
					if (rx_byte == rff_pkg::HEAD_BYTE) begin
						sum_d   = rx_byte;
						phase_d = rff_pkg::PH_DEV;
					end
				end
				rff_pkg::PH_DEV: begin
					sum_d   = sum_q + rx_byte;
					phase_d = rff_pkg::PH_SYS;
				end
				rff_pkg::PH_SYS: begin
					sum_d   = sum_q + rx_byte;
					phase_d = rff_pkg::PH_MSG;
				end
				rff_pkg::PH_MSG: begin
					sum_d   = sum_q + rx_byte;
					msg_d   = rx_byte;
					phase_d = rff_pkg::PH_SEQ;
				end
				rff_pkg::PH_SEQ: begin
					sum_d   = sum_q + rx_byte;
					phase_d = rff_pkg::PH_LEN;
				end
				rff_pkg::PH_LEN: begin
					sum_d = sum_q + rx_byte;
					len_d = rx_byte;
					if (rx_byte == 8'd0) begin
						phase_d = rff_pkg::PH_SUM;
					end else if (rx_byte > LenMax) begin
						phase_d = rff_pkg::PH_HUNT;
					end else begin
						cnt_d   = '0;
						phase_d = rff_pkg::PH_PAY;
					end
				end
				rff_pkg::PH_PAY: begin
					sum_d = sum_q + rx_byte;
					cnt_d = cnt_inc;
					if (8'(cnt_inc) >= len_q) begin
						phase_d = rff_pkg::PH_SUM;
					end
				end
				rff_pkg::PH_SUM: begin
					phase_d = rff_pkg::PH_HUNT;
					cnt_d   = '0;
					hit     = (rx_byte == sum_q) && (msg_q == rff_pkg::RANGE_MSG) &&
						(len_q == rff_pkg::RANGE_LEN);
				end
				default: begin
					phase_d = rff_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// Payload fields are written in place as their bytes go by.
	always_ff @(posedge clk) begin
		if (take && phase_q == rff_pkg::PH_PAY) begin
			case (8'(cnt_q))
				rff_pkg::OFF_DIST_B0:  dist_q[7:0]    <= rx_byte;
				rff_pkg::OFF_DIST_B1:  dist_q[15:8]   <= rx_byte;
				rff_pkg::OFF_DIST_B2:  dist_q[23:16]  <= rx_byte;
				rff_pkg::OFF_DIST_B3:  dist_q[31:24]  <= rx_byte;
				rff_pkg::OFF_STRENGTH: strength_q     <= rx_byte;
				rff_pkg::OFF_VX_LO:    vel_x_q[7:0]   <= rx_byte;
				rff_pkg::OFF_VX_HI:    vel_x_q[15:8]  <= rx_byte;
				rff_pkg::OFF_VY_LO:    vel_y_q[7:0]   <= rx_byte;
				rff_pkg::OFF_VY_HI:    vel_y_q[15:8]  <= rx_byte;
				rff_pkg::OFF_QUALITY:  quality_q      <= rx_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en.s1) begin
			valid_s1 <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1 && hit) begin
			frame_s1.vel_x    <= vel_x_q;
			frame_s1.vel_y    <= vel_y_q;
			frame_s1.distance <= dist_q;
			frame_s1.strength <= strength_q;
			frame_s1.quality  <= quality_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rff_flow_scale.sv
`default_nettype none

module rff_flow_scale (
	input  wire logic               clk,
	input  wire rff_pkg::stage_en_t en,
	input  wire logic [15:0]        vel,
	input  wire logic [31:0]        distance,
	output logic signed [15:0]      flow_s3
);

	logic [15:0] vel_abs;
	logic [47:0] mag;
	logic [47:0] mag_s2;
	logic        neg_s2;
	logic [44:0] recip_prod;
	logic [15:0] quot;
	logic signed [15:0] flow_d;

	assign vel_abs = vel[15] ? 16'(16'd0 - vel) : vel;
	assign mag     = 48'(vel_abs) * 48'(distance);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= mag;
			neg_s2 <= vel[15];
		end
	end

	// Only used below the saturation limits, where the magnitude fits in 25 bits.
	assign recip_prod = 45'(mag_s2[24:3]) * 45'(rff_pkg::RECIP_125);
	assign quot       = recip_prod[rff_pkg::RECIP_SHIFT +: 16];

	always_comb begin
		if (!neg_s2) begin
			if (mag_s2 >= rff_pkg::SAT_POS_MAG) begin
				flow_d = 16'sh7FFF;
			end else begin
				flow_d = $signed(quot);
			end
		end else begin
			if (mag_s2 >= rff_pkg::SAT_NEG_MAG) begin
				flow_d = 16'sh8000;
			end else begin
				flow_d = $signed(16'(16'd0 - quot));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			flow_s3 <= flow_d;
		end
	end

endmodule

`default_nettype wire
